// ===== design/qrb_pkg.sv =====
// Shared types, constants and helper functions of the quadratic root finder.
package qrb_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int SCAN_LIMIT_DEF  = 1024;

	localparam int TOL_WIDTH    = 17;
	localparam int ITER_WIDTH   = 7;
	localparam int STATUS_WIDTH = 3;
	localparam int CFG_WIDTH    = TOL_WIDTH;
	localparam int CFG_IDX_WIDTH = 1;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_ITER  = 1'd1;

	localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = 17'd1;
	localparam logic [ITER_WIDTH-1:0] ITER_RESET = 7'd48;
	localparam logic [ITER_WIDTH-1:0] ITER_MAX   = 7'd64;

	localparam logic [STATUS_WIDTH-1:0] ST_CONVERGED  = 3'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_NO_CHANGE  = 3'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_ITER_LIMIT = 3'd2;
	localparam logic [STATUS_WIDTH-1:0] ST_ZERO       = 3'd3;
	localparam logic [STATUS_WIDTH-1:0] ST_CLIPPED    = 3'd4;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_MUL,
		OP_SAVE_P,
		OP_SAVE_D,
		OP_BS_INIT,
		OP_BS_MID,
		OP_CLIP_M,
		OP_SAVE_T,
		OP_BS_STEP,
		OP_SAVE_CLIP,
		OP_SET_N,
		OP_SAVE_S1,
		OP_SAVE_S2,
		OP_SAVE_F,
		OP_PREV,
		OP_SCAN_DEC,
		OP_HIT,
		OP_NOCHANGE,
		OP_FOUND,
		OP_BIS_MID,
		OP_BIS_CHECK,
		OP_EMIT
	} op_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MS_BB,
		MS_CA,
		MS_AM,
		MS_TT,
		MS_XX,
		MS_AS,
		MS_BX
	} msel_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
	} cmd_t;

	typedef struct packed {
		logic a_zero;
		logic is_real;
		logic mul_done;
		logic lo_lt_hi;
		logic f_zero;
		logic sgn_chg;
		logic i_at_min;
		logic stop;
		logic out_free;
	} stat_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v[63] ? 64'(-v) : 64'(v);
		return r;
	endfunction

	function automatic logic signed [63:0] sadd64(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63])
			r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			r = s[63:0];
		return r;
	endfunction

endpackage

// ===== design/qrb_if.sv =====
// Request and result channel interfaces of the quadratic root finder.
interface qrb_req_if #(parameter int VALUE_WIDTH = qrb_pkg::VALUE_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] coef_a;
	logic signed [VALUE_WIDTH-1:0] coef_b;
	logic signed [VALUE_WIDTH-1:0] coef_c;
	modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrb_res_if #(parameter int VALUE_WIDTH = qrb_pkg::VALUE_WIDTH_DEF);
	logic                                  valid;
	logic                                  ready;
	logic signed [VALUE_WIDTH-1:0]         root;
	logic [qrb_pkg::STATUS_WIDTH-1:0]      status;
	logic [qrb_pkg::ITER_WIDTH-1:0]        steps_used;
	modport source(output valid, output root, output status, output steps_used, input ready);
	modport sink(input valid, input root, input status, input steps_used, output ready);
endinterface

// ===== design/qrb_mul.sv =====
// 64x64 unsigned multiplier built from four 32x32 partial products over cycles.
module qrb_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  x,
	input  logic [63:0]  y,
	output logic [127:0] prod,
	output logic         done
);

	logic [63:0]  x_q, y_q;
	logic [2:0]   cnt_q;
	logic         busy_q, pv_q, done_q;
	logic [1:0]   pidx_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [31:0]  xs, ys;
	logic [127:0] pp_sh;

	always_comb begin
		xs = cnt_q[1] ? x_q[63:32] : x_q[31:0];
		ys = cnt_q[0] ? y_q[63:32] : y_q[31:0];
	end

	always_comb begin
		unique case (pidx_q)
			2'd0: pp_sh = {64'd0, pp_q};
			2'd1: pp_sh = {32'd0, pp_q, 32'd0};
			2'd2: pp_sh = {32'd0, pp_q, 32'd0};
			2'd3: pp_sh = {pp_q, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 3'd4);
			pv_q   <= busy_q && (cnt_q != 3'd4);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + pp_sh;
		end
		pp_q   <= 64'(xs) * 64'(ys);
		pidx_q <= cnt_q[1:0];
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ===== design/qrb_datapath.sv =====
// Datapath: coefficient, bound, scan and bisection registers around one shared multiplier.
module qrb_datapath #(
	parameter int FRAC_BITS   = qrb_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = qrb_pkg::VALUE_WIDTH_DEF,
	parameter int SCAN_LIMIT  = qrb_pkg::SCAN_LIMIT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qrb_pkg::cmd_t                         cmd,
	output qrb_pkg::stat_t                        stat,
	input  logic                                  load,
	input  logic signed [VALUE_WIDTH-1:0]         coef_a,
	input  logic signed [VALUE_WIDTH-1:0]         coef_b,
	input  logic signed [VALUE_WIDTH-1:0]         coef_c,
	input  logic                                  cfg_we,
	input  logic [qrb_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [qrb_pkg::CFG_WIDTH-1:0]         cfg_data,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic signed [VALUE_WIDTH-1:0]         root,
	output logic [qrb_pkg::STATUS_WIDTH-1:0]      status,
	output logic [qrb_pkg::ITER_WIDTH-1:0]        steps_used
);

	localparam int CW = $clog2(SCAN_LIMIT + 2);
	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;
	localparam logic [CW-1:0] LIMIT  = CW'(SCAN_LIMIT);
	localparam logic [CW-1:0] LIMIT1 = CW'(SCAN_LIMIT + 1);

	logic signed [63:0] a_q, b_q, c_q;
	logic [127:0]       p_q, d_q;
	logic               real_q, clipped_q;
	logic [CW-1:0]      lo_q, hi_q, m_q, n_q;
	logic [63:0]        t_q;
	logic signed [CW:0] i_q;
	logic signed [63:0] px_q, s1_q, s2_q, f_q, prev_q, x1_q, x2_q, f1_q, root_q;
	logic [qrb_pkg::ITER_WIDTH-1:0]   k_q, limit_q, steps_q, maxit_q, steps_o_q;
	logic [qrb_pkg::STATUS_WIDTH-1:0] status_q, status_o_q;
	logic [qrb_pkg::TOL_WIDTH-1:0]    tol_q;
	logic signed [VALUE_WIDTH-1:0]    root_o_q;
	logic                             valid_q;

	logic [63:0]  mx, my;
	logic [127:0] prod;
	logic         mul_done;

	logic [127:0]       q2;
	logic               same_sign, fit, tol_hit, rfits;
	logic signed [63:0] fx_val, s3, f_next, mid;
	logic signed [64:0] sum65;
	logic signed [CW:0] i_dec, neg_n;
	logic signed [63:0] px_n, px_dec;
	logic [qrb_pkg::ITER_WIDTH-1:0] lim_clamp;
	logic signed [VALUE_WIDTH-1:0]  root_sat;

	function automatic logic signed [63:0] fx_trunc(input logic [127:0] pr, input logic neg);
		logic [63:0] lo;
		logic        ovf;
		lo  = pr[FRAC_BITS +: 64];
		ovf = (pr[127:FRAC_BITS+64] != '0) || lo[63];
		if (ovf)
			lo = {1'b0, {63{1'b1}}};
		return neg ? 64'(-$signed(lo)) : $signed(lo);
	endfunction

	function automatic logic signed [63:0] int_to_fx(input logic signed [CW:0] v);
		logic signed [63:0] e;
		e = {{(63-CW){v[CW]}}, v};
		return e <<< FRAC_BITS;
	endfunction

	always_comb begin
		unique case (cmd.msel)
			qrb_pkg::MS_BB: begin mx = qrb_pkg::mag64(b_q);  my = qrb_pkg::mag64(b_q);  end
			qrb_pkg::MS_CA: begin mx = qrb_pkg::mag64(c_q);  my = qrb_pkg::mag64(a_q);  end
			qrb_pkg::MS_AM: begin mx = qrb_pkg::mag64(a_q);  my = 64'(m_q);             end
			qrb_pkg::MS_TT: begin mx = t_q;                  my = t_q;                  end
			qrb_pkg::MS_XX: begin mx = qrb_pkg::mag64(px_q); my = qrb_pkg::mag64(px_q); end
			qrb_pkg::MS_AS: begin mx = qrb_pkg::mag64(a_q);  my = qrb_pkg::mag64(s1_q); end
			qrb_pkg::MS_BX: begin mx = qrb_pkg::mag64(b_q);  my = qrb_pkg::mag64(px_q); end
			default:        begin mx = '0;                   my = '0;                   end
		endcase
	end

	qrb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == qrb_pkg::OP_MUL),
		.x      (mx),
		.y      (my),
		.prod   (prod),
		.done   (mul_done)
	);

	always_comb begin
		q2        = {prod[126:0], 1'b0};
		same_sign = (c_q != 0) && (c_q[63] == a_q[63]);
		fit       = !(d_q < prod);
		unique case (cmd.op)
			qrb_pkg::OP_SAVE_S2: fx_val = fx_trunc(prod, a_q[63] ^ s1_q[63]);
			qrb_pkg::OP_SAVE_F:  fx_val = fx_trunc(prod, b_q[63] ^ px_q[63]);
			default:             fx_val = fx_trunc(prod, 1'b0);
		endcase
		s3      = fx_val;
		f_next  = qrb_pkg::sadd64(qrb_pkg::sadd64(s2_q, s3), c_q);
		sum65   = {x1_q[63], x1_q} + {x2_q[63], x2_q};
		mid     = sum65[64:1];
		i_dec   = i_q - (CW+1)'(1);
		neg_n   = (CW+1)'(0) - $signed({1'b0, n_q});
		px_n    = int_to_fx($signed({1'b0, lo_q}));
		px_dec  = int_to_fx(i_dec);
		tol_hit = qrb_pkg::mag64(f_q) < 64'(tol_q);
		if (maxit_q == '0)
			lim_clamp = qrb_pkg::ITER_WIDTH'(1);
		else if (maxit_q > qrb_pkg::ITER_MAX)
			lim_clamp = qrb_pkg::ITER_MAX;
		else
			lim_clamp = maxit_q;
		rfits = (&root_q[63:VALUE_WIDTH-1]) || !(|root_q[63:VALUE_WIDTH-1]);
		if (rfits)
			root_sat = root_q[VALUE_WIDTH-1:0];
		else if (root_q[63])
			root_sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
		else
			root_sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	end

	always_comb begin
		stat.a_zero   = (a_q == 0);
		stat.is_real  = real_q;
		stat.mul_done = mul_done;
		stat.lo_lt_hi = (lo_q < hi_q);
		stat.f_zero   = (f_q == 0);
		stat.sgn_chg  = (f_q[63] != prev_q[63]);
		stat.i_at_min = (i_q == neg_n);
		stat.stop     = (f_q == 0) || tol_hit || (k_q == limit_q);
		stat.out_free = !valid_q || res_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= qrb_pkg::TOL_RESET;
			maxit_q <= qrb_pkg::ITER_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					qrb_pkg::CFG_TOLERANCE: tol_q   <= cfg_data;
					qrb_pkg::CFG_MAX_ITER:  maxit_q <= cfg_data[qrb_pkg::ITER_WIDTH-1:0];
				endcase
			end
			if (cmd.op == qrb_pkg::OP_EMIT)
				valid_q <= 1'b1;
			else if (valid_q && res_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q      <= {{(64-VALUE_WIDTH){coef_a[VALUE_WIDTH-1]}}, coef_a};
			b_q      <= {{(64-VALUE_WIDTH){coef_b[VALUE_WIDTH-1]}}, coef_b};
			c_q      <= {{(64-VALUE_WIDTH){coef_c[VALUE_WIDTH-1]}}, coef_c};
			root_q   <= '0;
			status_q <= qrb_pkg::ST_NO_CHANGE;
			steps_q  <= '0;
		end
		unique case (cmd.op)
			qrb_pkg::OP_NONE, qrb_pkg::OP_MUL: ;
			qrb_pkg::OP_SAVE_P: p_q <= prod;
			qrb_pkg::OP_SAVE_D: begin
				if (same_sign) begin
					real_q <= !(p_q < q2);
					d_q    <= p_q - q2;
				end else begin
					real_q <= 1'b1;
					d_q    <= p_q + q2;
				end
			end
			qrb_pkg::OP_BS_INIT: begin
				lo_q <= '0;
				hi_q <= LIMIT;
			end
			qrb_pkg::OP_BS_MID:  m_q <= CW'(({1'b0, lo_q} + {1'b0, hi_q} + (CW+1)'(1)) >> 1);
			qrb_pkg::OP_CLIP_M:  m_q <= LIMIT1;
			qrb_pkg::OP_SAVE_T:  t_q <= prod[63:0];
			qrb_pkg::OP_BS_STEP: begin
				if (fit)
					lo_q <= m_q;
				else
					hi_q <= m_q - CW'(1);
			end
			qrb_pkg::OP_SAVE_CLIP: clipped_q <= fit;
			qrb_pkg::OP_SET_N: begin
				n_q  <= lo_q;
				i_q  <= $signed({1'b0, lo_q});
				px_q <= px_n;
			end
			qrb_pkg::OP_SAVE_S1: s1_q <= fx_val;
			qrb_pkg::OP_SAVE_S2: s2_q <= fx_val;
			qrb_pkg::OP_SAVE_F:  f_q  <= f_next;
			qrb_pkg::OP_PREV:    prev_q <= f_q;
			qrb_pkg::OP_SCAN_DEC: begin
				i_q  <= i_dec;
				px_q <= px_dec;
			end
			qrb_pkg::OP_HIT: begin
				root_q   <= px_q;
				status_q <= qrb_pkg::ST_ZERO;
			end
			qrb_pkg::OP_NOCHANGE:
				status_q <= clipped_q ? qrb_pkg::ST_CLIPPED : qrb_pkg::ST_NO_CHANGE;
			qrb_pkg::OP_FOUND: begin
				x1_q    <= px_q;
				x2_q    <= px_q + $signed(ONE);
				f1_q    <= f_q;
				k_q     <= '0;
				limit_q <= lim_clamp;
			end
			qrb_pkg::OP_BIS_MID: begin
				px_q <= mid;
				k_q  <= k_q + qrb_pkg::ITER_WIDTH'(1);
			end
			qrb_pkg::OP_BIS_CHECK: begin
				root_q  <= px_q;
				steps_q <= k_q;
				if (f_q == 0)
					status_q <= qrb_pkg::ST_ZERO;
				else if (tol_hit)
					status_q <= qrb_pkg::ST_CONVERGED;
				else begin
					status_q <= qrb_pkg::ST_ITER_LIMIT;
					if (f_q[63] != f1_q[63])
						x2_q <= px_q;
					else begin
						x1_q <= px_q;
						f1_q <= f_q;
					end
				end
			end
			qrb_pkg::OP_EMIT: begin
				root_o_q   <= root_sat;
				status_o_q <= status_q;
				steps_o_q  <= steps_q;
			end
			default: ;
		endcase
	end

	assign res_valid  = valid_q;
	assign root       = root_o_q;
	assign status     = status_o_q;
	assign steps_used = steps_o_q;

endmodule

// ===== design/qrb_ctrl.sv =====
// Controller: sequences bound search, integer scan and bisection over the datapath.
module qrb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  qrb_pkg::stat_t stat,
	output qrb_pkg::cmd_t  cmd,
	output logic           ready
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_W_P, S_M_Q, S_W_Q, S_G_D, S_T_D, S_G_BS, S_BS_T,
		S_BS_M1, S_BS_W1, S_BS_M2, S_BS_W2, S_N_S,
		S_P_START, S_P_W1, S_P_M2, S_P_W2, S_P_M3, S_P_W3, S_P_G, S_P_T,
		S_SC_NEXT, S_B_MID, S_EMIT_W
	} state_t;

	typedef enum logic [1:0] {PH_FIRST, PH_SCAN, PH_BIS} phase_t;

	state_t        state_q;
	phase_t        ph_q;
	qrb_pkg::cmd_t cmd_q;
	logic          ready_q, clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ph_q       <= PH_FIRST;
			cmd_q.op   <= qrb_pkg::OP_NONE;
			cmd_q.msel <= qrb_pkg::MS_BB;
			ready_q    <= 1'b1;
			clip_q     <= 1'b0;
		end else begin
			cmd_q.op <= qrb_pkg::OP_NONE;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					clip_q <= 1'b0;
					ph_q   <= PH_FIRST;
					if (stat.a_zero)
						state_q <= S_EMIT_W;
					else begin
						cmd_q.op   <= qrb_pkg::OP_MUL;
						cmd_q.msel <= qrb_pkg::MS_BB;
						state_q    <= S_W_P;
					end
				end
				S_W_P: if (stat.mul_done) begin
					cmd_q.op <= qrb_pkg::OP_SAVE_P;
					state_q  <= S_M_Q;
				end
				S_M_Q: begin
					cmd_q.op   <= qrb_pkg::OP_MUL;
					cmd_q.msel <= qrb_pkg::MS_CA;
					state_q    <= S_W_Q;
				end
				S_W_Q: if (stat.mul_done) begin
					cmd_q.op <= qrb_pkg::OP_SAVE_D;
					state_q  <= S_G_D;
				end
				S_G_D: state_q <= S_T_D;
				S_T_D: begin
					if (stat.is_real) begin
						cmd_q.op <= qrb_pkg::OP_BS_INIT;
						state_q  <= S_G_BS;
					end else
						state_q <= S_EMIT_W;
				end
				S_G_BS: state_q <= S_BS_T;
				S_BS_T: begin
					if (stat.lo_lt_hi)
						cmd_q.op <= qrb_pkg::OP_BS_MID;
					else begin
						cmd_q.op <= qrb_pkg::OP_CLIP_M;
						clip_q   <= 1'b1;
					end
					state_q <= S_BS_M1;
				end
				S_BS_M1: begin
					cmd_q.op   <= qrb_pkg::OP_MUL;
					cmd_q.msel <= qrb_pkg::MS_AM;
					state_q    <= S_BS_W1;
				end
				S_BS_W1: if (stat.mul_done) begin
					cmd_q.op <= qrb_pkg::OP_SAVE_T;
					state_q  <= S_BS_M2;
				end
				S_BS_M2: begin
					cmd_q.op   <= qrb_pkg::OP_MUL;
					cmd_q.msel <= qrb_pkg::MS_TT;
					state_q    <= S_BS_W2;
				end
				S_BS_W2: if (stat.mul_done) begin
					if (clip_q) begin
						cmd_q.op <= qrb_pkg::OP_SAVE_CLIP;
						state_q  <= S_N_S;
					end else begin
						cmd_q.op <= qrb_pkg::OP_BS_STEP;
						state_q  <= S_G_BS;
					end
				end
				S_N_S: begin
					cmd_q.op <= qrb_pkg::OP_SET_N;
					state_q  <= S_P_START;
				end
				// f(px) = a*(px*px) + b*px + c
				S_P_START: begin
					cmd_q.op   <= qrb_pkg::OP_MUL;
					cmd_q.msel <= qrb_pkg::MS_XX;
					state_q    <= S_P_W1;
				end
				S_P_W1: if (stat.mul_done) begin
					cmd_q.op <= qrb_pkg::OP_SAVE_S1;
					state_q  <= S_P_M2;
				end
				S_P_M2: begin
					cmd_q.op   <= qrb_pkg::OP_MUL;
					cmd_q.msel <= qrb_pkg::MS_AS;
					state_q    <= S_P_W2;
				end
				S_P_W2: if (stat.mul_done) begin
					cmd_q.op <= qrb_pkg::OP_SAVE_S2;
					state_q  <= S_P_M3;
				end
				S_P_M3: begin
					cmd_q.op   <= qrb_pkg::OP_MUL;
					cmd_q.msel <= qrb_pkg::MS_BX;
					state_q    <= S_P_W3;
				end
				S_P_W3: if (stat.mul_done) begin
					cmd_q.op <= qrb_pkg::OP_SAVE_F;
					state_q  <= S_P_G;
				end
				S_P_G: state_q <= S_P_T;
				S_P_T: begin
					unique case (ph_q)
						PH_FIRST: begin
							if (stat.f_zero) begin
								cmd_q.op <= qrb_pkg::OP_HIT;
								state_q  <= S_EMIT_W;
							end else begin
								cmd_q.op <= qrb_pkg::OP_PREV;
								state_q  <= S_SC_NEXT;
							end
						end
						PH_SCAN: begin
							priority if (stat.f_zero) begin
								cmd_q.op <= qrb_pkg::OP_HIT;
								state_q  <= S_EMIT_W;
							end else if (stat.sgn_chg) begin
								cmd_q.op <= qrb_pkg::OP_FOUND;
								ph_q     <= PH_BIS;
								state_q  <= S_B_MID;
							end else begin
								cmd_q.op <= qrb_pkg::OP_PREV;
								state_q  <= S_SC_NEXT;
							end
						end
						PH_BIS: begin
							cmd_q.op <= qrb_pkg::OP_BIS_CHECK;
							state_q  <= stat.stop ? S_EMIT_W : S_B_MID;
						end
						default: state_q <= S_EMIT_W;
					endcase
				end
				S_SC_NEXT: begin
					if (stat.i_at_min) begin
						cmd_q.op <= qrb_pkg::OP_NOCHANGE;
						state_q  <= S_EMIT_W;
					end else begin
						cmd_q.op <= qrb_pkg::OP_SCAN_DEC;
						ph_q     <= PH_SCAN;
						state_q  <= S_P_START;
					end
				end
				S_B_MID: begin
					cmd_q.op <= qrb_pkg::OP_BIS_MID;
					state_q  <= S_P_START;
				end
				S_EMIT_W: if (stat.out_free) begin
					cmd_q.op <= qrb_pkg::OP_EMIT;
					ready_q  <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd   = cmd_q;
	assign ready = ready_q;

endmodule

// ===== design/quadratic_root_bisection.sv =====
// Top level of the quadratic root finder: bound search, integer scan, bisection.
//
// request: one beat carries coef_a, coef_b, coef_c (signed Q FRAC_BITS).
// result:  one beat per request with root (last bisection midpoint, or the scan point where f is zero; saturated),
//          status and steps_used.
// cfg_we/cfg_index/cfg_data write tolerance (index 0) or max_iterations
// (index 1); write only while no request is in flight.
// One request is worked at a time; ready drops at accept and rises when the
// result is moved to the output register. Every evaluation goes through one
// shared 64x64 multiplier built from 32x32 partial products. Reset sets
// tolerance to 1 and max_iterations to 48, drops result valid and makes the
// block ready. A result waits in the output register while the receiver
// stalls; the next request is still taken and worked, and its result waits
// until the register is free.
module quadratic_root_bisection #(
	parameter int FRAC_BITS   = qrb_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = qrb_pkg::VALUE_WIDTH_DEF,
	parameter int SCAN_LIMIT  = qrb_pkg::SCAN_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	qrb_req_if.sink                           request,
	qrb_res_if.source                         result,
	input  logic                              cfg_we,
	input  logic [qrb_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [qrb_pkg::CFG_WIDTH-1:0]     cfg_data
);

	qrb_pkg::cmd_t  cmd;
	qrb_pkg::stat_t stat;
	logic           ready, accept;

	assign request.ready = ready;
	assign accept        = request.valid && ready;

	qrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.cmd    (cmd),
		.ready  (ready)
	);

	qrb_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.VALUE_WIDTH (VALUE_WIDTH),
		.SCAN_LIMIT  (SCAN_LIMIT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.load       (accept),
		.coef_a     (request.coef_a),
		.coef_b     (request.coef_b),
		.coef_c     (request.coef_c),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.root       (result.root),
		.status     (result.status),
		.steps_used (result.steps_used)
	);

endmodule

// ===== tb/sv/quadratic_root_bisection_tb.sv =====
// Self-checking testbench of the quadratic root finder: directed table, random phases, scoreboard.
module quadratic_root_bisection_tb;

	localparam int ONE = 1 << 16;
	localparam int RAND_PER_PHASE = 222;

	typedef struct {
		logic signed [31:0] a, b, c;
		bit                 typed;
		logic signed [31:0] root;
		logic [2:0]         status;
		logic [6:0]         steps;
	} coef_row_t;

	typedef struct {
		logic signed [31:0] root;
		logic [2:0]         status;
		logic [6:0]         steps;
	} root_t;

	typedef struct {
		logic [16:0] tol;
		logic [6:0]  iters;
	} setting_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [qrb_pkg::CFG_IDX_WIDTH-1:0] cfg_index = qrb_pkg::CFG_TOLERANCE;
	logic [qrb_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	qrb_req_if req_if();
	qrb_res_if res_if();

	quadratic_root_bisection dut (
		.clk(clk), .arst_n(arst_n), .request(req_if), .result(res_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		#400_000_000;
		$display("Regression FAIL");
		$finish;
	end

	logic [16:0] cur_tol = qrb_pkg::TOL_RESET;
	logic [6:0]  cur_iters = qrb_pkg::ITER_RESET;
	root_t       roots_due[$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;
	int          status_seen[8];
	int          beats_out = 0;

	coef_row_t dir_tab [14] = '{
		'{32'sd0, 32'sd5, 32'sd7, 1, 32'sd0, qrb_pkg::ST_NO_CHANGE, 7'd0},
		// complex roots
		'{ONE, 32'sd0, ONE, 1, 32'sd0, qrb_pkg::ST_NO_CHANGE, 7'd0},
		'{ONE, 32'sd0, -4 * ONE, 1, 2 * ONE, qrb_pkg::ST_ZERO, 7'd0},
		'{ONE, 32'sd0, 32'sd0, 1, 32'sd0, qrb_pkg::ST_ZERO, 7'd0},
		// roots far outside the scan window, f negative across it
		'{32'sd1, 32'sd0, 32'h8000_0000, 1, 32'sd0, qrb_pkg::ST_CLIPPED, 7'd0},
		'{ONE, 32'sd0, -2 * ONE, 0, 0, 0, 0},
		'{-3 * ONE, 5 * ONE, 7 * ONE, 0, 0, 0, 0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
		'{32'h8000_0000, 32'sd0, 32'h7FFF_FFFF, 0, 0, 0, 0},
		'{32'h7FFF_FFFF, 32'sd0, 32'h8000_0000, 0, 0, 0, 0},
		'{2 * ONE, -3 * ONE, -ONE / 2, 0, 0, 0, 0},
		'{ONE / 4, ONE, -5 * ONE, 0, 0, 0, 0},
		'{-ONE, 32'sd3, 32'sd9, 0, 0, 0, 0}
	};

	setting_t settings [6] = '{
		'{17'd1, 7'd48}, '{17'd0, 7'd64}, '{17'd65536, 7'd1},
		'{17'd300, 7'd0}, '{17'd0, 7'd127}, '{17'd37, 7'd20}
	};

	function automatic logic [63:0] abs_val(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] q_mul(input logic signed [63:0] p,
			input logic signed [63:0] q);
		logic [127:0] full;
		logic [63:0]  m;
		full = ({64'd0, abs_val(p)} * {64'd0, abs_val(q)}) >> 16;
		m = (full > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : full[63:0];
		return ((p < 0) != (q < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] quad_at(input logic signed [63:0] x,
			input logic signed [63:0] a, input logic signed [63:0] b,
			input logic signed [63:0] c);
		return sat_sum(sat_sum(q_mul(a, q_mul(x, x)), q_mul(b, x)), c);
	endfunction

	function automatic bit bound_fits(input logic [63:0] am, input logic [63:0] n,
			input logic [127:0] d);
		logic [63:0] t;
		t = am * n;
		return d >= {64'd0, t} * {64'd0, t};
	endfunction

	function automatic root_t solve_quad(input logic signed [31:0] a32,
			input logic signed [31:0] b32, input logic signed [31:0] c32);
		root_t r;
		logic signed [63:0] a, b, c, n, i, prev, cur, x1, x2, f1, mid, fm, root;
		logic [63:0]  am, lo, hi, m, limit;
		logic [127:0] p, q, d;
		bit real_ok, clipped, found, done;
		a = a32; b = b32; c = c32;
		root = 0; r.status = qrb_pkg::ST_NO_CHANGE; r.steps = 0;
		if (a != 0) begin
			am = abs_val(a);
			p = {64'd0, abs_val(b)} * {64'd0, abs_val(b)};
			q = ({64'd0, abs_val(c)} * {64'd0, am}) << 1;
			real_ok = 1;
			d = '0;
			if (c != 0 && ((c < 0) == (a < 0))) begin
				if (p < q) real_ok = 0;
				else d = p - q;
			end else begin
				d = p + q;
			end
			if (real_ok) begin
				lo = 0; hi = qrb_pkg::SCAN_LIMIT_DEF;
				while (lo < hi) begin
					m = (lo + hi + 1) / 2;
					if (bound_fits(am, m, d)) lo = m;
					else hi = m - 1;
				end
				clipped = bound_fits(am, qrb_pkg::SCAN_LIMIT_DEF + 1, d);
				n = lo;
				found = 0; done = 0; x1 = 0;
				prev = quad_at(n * ONE, a, b, c);
				if (prev == 0) begin
					root = n * ONE; r.status = qrb_pkg::ST_ZERO; done = 1;
				end
				for (i = n - 1; !done && i >= -n; i--) begin
					cur = quad_at(i * ONE, a, b, c);
					if (cur == 0) begin
						root = i * ONE; r.status = qrb_pkg::ST_ZERO; done = 1;
					end else if ((cur < 0) != (prev < 0)) begin
						x1 = i * ONE; found = 1; done = 1;
					end
					prev = cur;
				end
				if (!done)
					r.status = clipped ? qrb_pkg::ST_CLIPPED : qrb_pkg::ST_NO_CHANGE;
				if (found) begin
					x2 = x1 + ONE; f1 = prev;
					limit = cur_iters;
					if (limit < 1) limit = 1;
					if (limit > 64) limit = 64;
					r.status = qrb_pkg::ST_ITER_LIMIT;
					for (int k = 1; k <= limit; k++) begin
						mid = x1 + (x2 - x1) / 2;
						fm = quad_at(mid, a, b, c);
						root = mid;
						r.steps = 7'(k);
						if (fm == 0) begin
							r.status = qrb_pkg::ST_ZERO;
							break;
						end
						if (abs_val(fm) < {47'd0, cur_tol}) begin
							r.status = qrb_pkg::ST_CONVERGED;
							break;
						end
						if ((fm < 0) != (f1 < 0)) begin
							x2 = mid;
						end else begin
							x1 = mid; f1 = fm;
						end
					end
				end
			end
		end
		if (root > 64'sh7FFF_FFFF) root = 64'sh7FFF_FFFF;
		if (root < -64'sh8000_0000) root = -64'sh8000_0000;
		r.root = root[31:0];
		return r;
	endfunction

	// Mostly small bounds so the scan stays short; a few raw noise items.
	task automatic pick_coefs(output logic signed [31:0] a, output logic signed [31:0] b,
			output logic signed [31:0] c);
		int kind;
		logic signed [63:0] a64, s, t;
		kind = $urandom_range(99);
		if (kind < 2) begin
			a = $urandom; b = $urandom; c = $urandom;
		end else if (kind < 6) begin
			a = (kind < 4) ? 32'sd0 : $urandom;
			b = $urandom_range(0, 3 * ONE);
			c = (a < 0) ? -$signed(32'($urandom_range(ONE, 40 * ONE)))
				: $signed(32'($urandom_range(ONE, 40 * ONE)));
			if (kind < 4) c = $urandom;
		end else if (kind < 18) begin
			s = $urandom_range(1, 8);
			a64 = $signed(64'($urandom_range(0, 12))) - 6;
			t = $signed(64'($urandom_range(0, 12))) - 6;
			a = 32'(s * ONE);
			b = 32'(-s * (a64 + t) * ONE);
			c = 32'(s * a64 * t * ONE);
		end else begin
			a64 = $urandom_range(1 << 12, 1 << 21);
			if ($urandom_range(1)) a64 = -a64;
			s = $signed(64'($urandom_range(0, 16 * ONE))) - 8 * ONE;
			t = $signed(64'($urandom_range(0, 40 * ONE))) - 20 * ONE;
			a = 32'(a64);
			b = 32'((a64 * s) >>> 16);
			c = 32'((a64 * t) >>> 16);
		end
	endtask

	task automatic send_coefs(input coef_row_t row);
		root_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid = 0;
			@(negedge clk);
		end
		req_if.valid = 1;
		req_if.coef_a = row.a;
		req_if.coef_b = row.b;
		req_if.coef_c = row.c;
		do @(posedge clk); while (!req_if.ready);
		if (row.typed) begin
			e.root = row.root; e.status = row.status; e.steps = row.steps;
		end else begin
			e = solve_quad(row.a, row.b, row.c);
		end
		roots_due = {roots_due, e};
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [qrb_pkg::CFG_IDX_WIDTH-1:0] idx,
			input logic [16:0] val);
		cfg_we = 1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		if (idx == qrb_pkg::CFG_TOLERANCE) cur_tol = val;
		else cur_iters = val[6:0];
	endtask

	task automatic drain_roots();
		req_if.valid = 0;
		while (roots_due.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_if.ready = 0;
			hold_cycles = hold_cycles - 1;
		end else begin
			res_if.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		root_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			beats_out++;
			status_seen[res_if.status]++;
			if (roots_due.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = roots_due.pop_front();
				if (res_if.root !== e.root) begin
					$error("root: expected %0d, got %0d", e.root, res_if.root);
					errors++;
				end
				if (res_if.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, res_if.status);
					errors++;
				end
				if (res_if.steps_used !== e.steps) begin
					$error("steps_used: expected %0d, got %0d", e.steps, res_if.steps_used);
					errors++;
				end
			end
		end
	end

	initial begin
		coef_row_t row;
		req_if.valid = 0;
		req_if.coef_a = '0; req_if.coef_b = '0; req_if.coef_c = '0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_idle_pct = 37; recv_idle_pct = 58;
		foreach (dir_tab[k]) send_coefs(dir_tab[k]);
		for (int ph = 0; ph < 6; ph++) begin
			drain_roots();
			write_reg(qrb_pkg::CFG_TOLERANCE, settings[ph].tol);
			write_reg(qrb_pkg::CFG_MAX_ITER, {10'd0, settings[ph].iters});
			send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 58 : 0;
			recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 37 : 0;
			// long receiver stall: output register and input side back up
			if (ph == 4) hold_cycles = 4000;
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				pick_coefs(row.a, row.b, row.c);
				row.typed = 0;
				send_coefs(row);
			end
		end
		drain_roots();
		$display("Checked %0d roots over 6 tolerance/iteration settings and 3 idle mixes.",
			beats_out);
		$display("Status counts: conv %0d, none %0d, limit %0d, zero %0d, clipped %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/qrb_pkg.sv
design/qrb_if.sv
design/qrb_mul.sv
design/qrb_datapath.sv
design/qrb_ctrl.sv
design/quadratic_root_bisection.sv
tb/sv/quadratic_root_bisection_tb.sv
